### hw/rtl/ray_sphere_intersect_distance_macros.svh
// Assertion helpers for the ray and sphere block.
`ifndef RAY_SPHERE_INTERSECT_DISTANCE_MACROS_SVH
`define RAY_SPHERE_INTERSECT_DISTANCE_MACROS_SVH

// Same-cycle implication.
`define RSID_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rsid assertion failed");

// Next-cycle implication.
`define RSID_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rsid assertion failed");

`endif

### hw/rtl/rsid_pkg.sv
`default_nettype none
package rsid_pkg;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 2'd3;

  localparam int DIR_BITS = 30;
  localparam int ROOT_W   = 32;
  localparam int RAD_W    = 2 * ROOT_W;
  localparam int QUOT_W   = DIR_BITS + 1;
  localparam int DEN_W    = 32;
  localparam int NUM_W    = QUOT_W + DEN_W;
  localparam int C_W      = 33;
  localparam int CC_W     = 67;
  localparam int TM_W     = 34;
  localparam int T_W      = TM_W + 1;

  typedef struct packed {
    logic [2:0][31:0]    m;
    logic [2:0][C_W-1:0] c;
    logic [2:0]          dsign;
    logic                cdneg;
    logic [CC_W-1:0]     cc;
    logic                zero;
  } rsid_sq1_t;

  typedef struct packed {
    logic [2:0][C_W-1:0] c;
    logic [2:0]          dsign;
    logic                cdneg;
    logic [CC_W-1:0]     cc;
    logic                zero;
  } rsid_div_t;

  typedef struct packed {
    logic signed [T_W-1:0] t;
    logic                  in_sph;
    logic                  miss;
  } rsid_sq2_t;

endpackage
`default_nettype wire

### hw/rtl/rsid_isqrt.sv
`default_nettype none
module rsid_isqrt #(
  parameter int PW = 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic [rsid_pkg::RAD_W-1:0]     radicand,
  input  logic [PW-1:0]                  in_pay,
  output logic                           out_valid,
  output logic [rsid_pkg::ROOT_W-1:0]    root,
  output logic [rsid_pkg::ROOT_W:0]      rem,
  output logic [PW-1:0]                  out_pay
);

  localparam int N  = rsid_pkg::ROOT_W;
  localparam int RW = rsid_pkg::RAD_W;

  logic [RW-1:0] x_a [N+1];
  logic [RW-1:0] r_a [N+1];
  logic [PW-1:0] p_a [N+1];
  logic          v_a [N+1];

  assign x_a[0] = radicand;
  assign r_a[0] = '0;
  assign p_a[0] = in_pay;
  assign v_a[0] = in_valid;

  for (genvar i = 0; i < N; i++) begin : g_step
    localparam logic [RW-1:0] BIT = RW'(1) << (RW - 2 - 2 * i);
    logic [RW-1:0] trial;
    logic          take;
    assign trial = r_a[i] + BIT;
    assign take  = x_a[i] >= trial;
    always_ff @(posedge clk) begin
      if (rst) begin
        v_a[i+1] <= 1'b0;
      end else if (en) begin
        v_a[i+1] <= v_a[i];
      end
      if (en) begin
        x_a[i+1] <= take ? x_a[i] - trial : x_a[i];
        r_a[i+1] <= take ? (r_a[i] >> 1) + BIT : r_a[i] >> 1;
        p_a[i+1] <= p_a[i];
      end
    end
  end

  assign out_valid = v_a[N];
  assign root      = r_a[N][N-1:0];
  assign rem       = x_a[N][N:0];
  assign out_pay   = p_a[N];

endmodule
`default_nettype wire

### hw/rtl/rsid_div3.sv
`default_nettype none
module rsid_div3 #(
  parameter int PW = 1
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic [2:0][rsid_pkg::NUM_W-1:0]     numer,
  input  logic [rsid_pkg::DEN_W-1:0]          den,
  input  logic [PW-1:0]                       in_pay,
  output logic                                out_valid,
  output logic [2:0][rsid_pkg::QUOT_W-1:0]    quot,
  output logic [PW-1:0]                       out_pay
);

  localparam int QW = rsid_pkg::QUOT_W;
  localparam int DW = rsid_pkg::DEN_W;
  localparam int NW = rsid_pkg::NUM_W;

  logic [2:0][DW-1:0] rem_a [QW+1];
  logic [2:0][QW-1:0] q_a   [QW+1];
  logic [2:0][NW-1:0] n_a   [QW+1];
  logic [DW-1:0]      d_a   [QW+1];
  logic [PW-1:0]      p_a   [QW+1];
  logic               v_a   [QW+1];

  for (genvar l = 0; l < 3; l++) begin : g_init
    assign rem_a[0][l] = numer[l][NW-1:QW];
    assign q_a[0][l]   = '0;
  end
  assign n_a[0] = numer;
  assign d_a[0] = den;
  assign p_a[0] = in_pay;
  assign v_a[0] = in_valid;

  for (genvar i = 0; i < QW; i++) begin : g_step
    logic [2:0][DW-1:0] rem_next;
    logic [2:0][QW-1:0] q_next;
    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [DW:0] trial;
      logic [DW:0] diff;
      logic        ge;
      assign trial = {rem_a[i][l], n_a[i][l][QW-1-i]};
      assign diff  = trial - {1'b0, d_a[i]};
      assign ge    = trial >= {1'b0, d_a[i]};
      assign rem_next[l] = ge ? diff[DW-1:0] : trial[DW-1:0];
      assign q_next[l]   = {q_a[i][l][QW-2:0], ge};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        v_a[i+1] <= 1'b0;
      end else if (en) begin
        v_a[i+1] <= v_a[i];
      end
      if (en) begin
        rem_a[i+1] <= rem_next;
        q_a[i+1]   <= q_next;
        n_a[i+1]   <= n_a[i];
        d_a[i+1]   <= d_a[i];
        p_a[i+1]   <= p_a[i];
      end
    end
  end

  assign out_valid = v_a[QW];
  assign quot      = q_a[QW];
  assign out_pay   = p_a[QW];

endmodule
`default_nettype wire

### hw/rtl/ray_sphere_intersect_distance.sv
// Ray against sphere distance unit, one ray per clock while in_ready is high.
// Configuration: write center_x/y/z and radius (indexes 0..3) on the cfg
//   channel while no ray is in flight; cfg_ready is always high.
// Input: start_* and dir_* (signed Q16.16) on in_valid/in_ready.
// Output: hit, inside_res and distance (unsigned Q16.16, saturating) on
//   out_valid/out_ready; a miss gives zero distance and inside_res low.
// Pipeline: front end, direction length root, normalize, divide, dot and
//   tests, chord root, final add and output register, in that order.
// Throughput: one ray per cycle while in_ready is high, set by the fully
//   pipelined root and divide units that retire one bit per stage.
// Stall: when out_ready is low a skid register absorbs one more result, then
//   in_ready drops and the whole pipeline holds until the skid drains.
// Reset: synchronous, clears all valid bits and sets the configuration registers to zero.
`default_nettype none
module ray_sphere_intersect_distance #(
  parameter int TOL_DIVISOR = 1000
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rsid_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                       cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [31:0]                start_x,
  input  logic signed [31:0]                start_y,
  input  logic signed [31:0]                start_z,
  input  logic signed [31:0]                dir_x,
  input  logic signed [31:0]                dir_y,
  input  logic signed [31:0]                dir_z,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              hit,
  output logic                              inside_res,
  output logic [31:0]                       distance
);

  localparam int TW  = $clog2(TOL_DIVISOR + 2);
  localparam int SQW = 2 * TW;
  localparam int CW  = rsid_pkg::CC_W + SQW;
  localparam logic [SQW-1:0] TSQ =
    SQW'(longint'(TOL_DIVISOR) * longint'(TOL_DIVISOR));
  localparam logic [SQW-1:0] TM1SQ =
    SQW'(longint'(TOL_DIVISOR - 1) * longint'(TOL_DIVISOR - 1));
  localparam logic [SQW-1:0] TP1SQ =
    SQW'(longint'(TOL_DIVISOR + 1) * longint'(TOL_DIVISOR + 1));
  localparam int CBW = rsid_pkg::C_W;
  localparam int CCW = rsid_pkg::CC_W;
  localparam int RW  = rsid_pkg::RAD_W;

  // configuration
  logic signed [31:0] center_x, center_y, center_z;
  logic [30:0]        radius;
  logic [61:0]        r2;
  logic [CW-1:0]      rs_lim, ri_lim;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= '0;
      center_y <= '0;
      center_z <= '0;
      radius   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        rsid_pkg::REG_CENTER_X: center_x <= cfg_data;
        rsid_pkg::REG_CENTER_Y: center_y <= cfg_data;
        rsid_pkg::REG_CENTER_Z: center_z <= cfg_data;
        rsid_pkg::REG_RADIUS:   radius   <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    r2     <= 62'(radius) * 62'(radius);
    rs_lim <= CW'(r2) * CW'(TM1SQ);
    ri_lim <= CW'(r2) * CW'(TP1SQ);
  end

  // pipeline enable and output skid
  logic skid_valid;
  logic en;
  assign en       = !skid_valid;
  assign in_ready = en;

  // F1: offsets
  logic signed [31:0] sin [3];
  logic signed [31:0] cen [3];
  logic signed [31:0] din [3];
  assign sin[0] = start_x;  assign sin[1] = start_y;  assign sin[2] = start_z;
  assign cen[0] = center_x; assign cen[1] = center_y; assign cen[2] = center_z;
  assign din[0] = dir_x;    assign din[1] = dir_y;    assign din[2] = dir_z;

  logic                  f1_v;
  logic signed [CBW-1:0] f1_c [3];
  logic signed [31:0]    f1_d [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_v <= 1'b0;
    end else if (en) begin
      f1_v <= in_valid;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        f1_c[i] <= {cen[i][31], cen[i]} - {sin[i][31], sin[i]};
        f1_d[i] <= din[i];
      end
    end
  end

  // F2: magnitudes and raw products
  logic [31:0]           dmag [3];
  logic signed [65:0]    csq_full [3];
  logic [31:0]           mx_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dmag[i]     = f1_d[i][31] ? ~f1_d[i] + 32'd1 : f1_d[i];
      csq_full[i] = f1_c[i] * f1_c[i];
    end
    mx_c = dmag[0];
    if (dmag[1] > mx_c) mx_c = dmag[1];
    if (dmag[2] > mx_c) mx_c = dmag[2];
  end

  logic                  f2_v;
  logic signed [CBW-1:0] f2_c [3];
  logic [2:0]            f2_dsign;
  logic [31:0]           f2_dmag [3];
  logic [31:0]           f2_mx;
  logic signed [64:0]    f2_pcd [3];
  logic [64:0]           f2_csq [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      f2_v <= 1'b0;
    end else if (en) begin
      f2_v <= f1_v;
    end
    if (en) begin
      f2_mx <= mx_c;
      for (int i = 0; i < 3; i++) begin
        f2_c[i]     <= f1_c[i];
        f2_dsign[i] <= f1_d[i][31];
        f2_dmag[i]  <= dmag[i];
        f2_pcd[i]   <= f1_c[i] * f1_d[i];
        f2_csq[i]   <= csq_full[i][64:0];
      end
    end
  end

  // F3: normalize shift and sums
  logic [4:0]           k_c;
  logic signed [66:0]   cdsum_c;
  logic [CCW-1:0]       ccsum_c;
  rsid_pkg::rsid_sq1_t  f3_c;

  always_comb begin
    k_c = '0;
    for (int i = 0; i < 31; i++) begin
      if (f2_mx[i]) k_c = 5'(30 - i);
    end
    if (f2_mx[31]) k_c = '0;
    cdsum_c = 67'(f2_pcd[0]) + 67'(f2_pcd[1]) + 67'(f2_pcd[2]);
    ccsum_c = CCW'(f2_csq[0]) + CCW'(f2_csq[1]) + CCW'(f2_csq[2]);
    for (int i = 0; i < 3; i++) begin
      f3_c.m[i]     = f2_dmag[i] << k_c;
      f3_c.c[i]     = f2_c[i];
      f3_c.dsign[i] = f2_dsign[i];
    end
    f3_c.cdneg = cdsum_c[66];
    f3_c.cc    = ccsum_c;
    f3_c.zero  = f2_mx == '0;
  end

  logic                f3_v;
  rsid_pkg::rsid_sq1_t f3_p;

  always_ff @(posedge clk) begin
    if (rst) begin
      f3_v <= 1'b0;
    end else if (en) begin
      f3_v <= f2_v;
    end
    if (en) f3_p <= f3_c;
  end

  // F4: squares of the normalized direction
  logic                f4_v;
  rsid_pkg::rsid_sq1_t f4_p;
  logic [63:0]         f4_msq [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      f4_v <= 1'b0;
    end else if (en) begin
      f4_v <= f3_v;
    end
    if (en) begin
      f4_p <= f3_p;
      for (int i = 0; i < 3; i++) begin
        f4_msq[i] <= 64'(f3_p.m[i]) * 64'(f3_p.m[i]);
      end
    end
  end

  // F5: squared length
  logic                f5_v;
  rsid_pkg::rsid_sq1_t f5_p;
  logic [RW-1:0]       f5_dd;

  always_ff @(posedge clk) begin
    if (rst) begin
      f5_v <= 1'b0;
    end else if (en) begin
      f5_v <= f4_v;
    end
    if (en) begin
      f5_p  <= f4_p;
      f5_dd <= f4_msq[0] + f4_msq[1] + f4_msq[2];
    end
  end

  // length root
  logic                             sq1_v;
  logic [rsid_pkg::ROOT_W-1:0]      len;
  rsid_pkg::rsid_sq1_t              sq1_p;

  rsid_isqrt #(
    .PW ($bits(rsid_pkg::rsid_sq1_t))
  ) u_len_root (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f5_v),
    .radicand  (f5_dd),
    .in_pay    (f5_p),
    .out_valid (sq1_v),
    .root      (len),
    .rem       (),
    .out_pay   (sq1_p)
  );

  // F6: rounded numerators
  logic                                  f6_v;
  logic [2:0][rsid_pkg::NUM_W-1:0]       f6_num;
  logic [rsid_pkg::DEN_W-1:0]            f6_den;
  rsid_pkg::rsid_div_t                   f6_p;

  always_ff @(posedge clk) begin
    if (rst) begin
      f6_v <= 1'b0;
    end else if (en) begin
      f6_v <= sq1_v;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        f6_num[i] <= {1'b0, sq1_p.m[i], rsid_pkg::DIR_BITS'(0)}
                     + rsid_pkg::NUM_W'(len >> 1);
      end
      f6_den     <= len;
      f6_p.c     <= sq1_p.c;
      f6_p.dsign <= sq1_p.dsign;
      f6_p.cdneg <= sq1_p.cdneg;
      f6_p.cc    <= sq1_p.cc;
      f6_p.zero  <= sq1_p.zero;
    end
  end

  // unit direction
  logic                               dv_v;
  logic [2:0][rsid_pkg::QUOT_W-1:0]   dq;
  rsid_pkg::rsid_div_t                dv_p;

  rsid_div3 #(
    .PW ($bits(rsid_pkg::rsid_div_t))
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f6_v),
    .numer     (f6_num),
    .den       (f6_den),
    .in_pay    (f6_p),
    .out_valid (dv_v),
    .quot      (dq),
    .out_pay   (dv_p)
  );

  // B1: c times unit direction
  logic signed [31:0] dn [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dn[i] = dv_p.dsign[i] ? -$signed({1'b0, dq[i]}) : $signed({1'b0, dq[i]});
    end
  end

  logic               b1_v;
  logic signed [64:0] b1_pr [3];
  logic               b1_cdneg, b1_zero;
  logic [CCW-1:0]     b1_cc;

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_v <= 1'b0;
    end else if (en) begin
      b1_v <= dv_v;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        b1_pr[i] <= $signed(dv_p.c[i]) * dn[i];
      end
      b1_cdneg <= dv_p.cdneg;
      b1_zero  <= dv_p.zero;
      b1_cc    <= dv_p.cc;
    end
  end

  // B2: dot product
  logic               b2_v;
  logic signed [66:0] b2_sum;
  logic               b2_cdneg, b2_zero;
  logic [CCW-1:0]     b2_cc;

  always_ff @(posedge clk) begin
    if (rst) begin
      b2_v <= 1'b0;
    end else if (en) begin
      b2_v <= b1_v;
    end
    if (en) begin
      b2_sum   <= 67'(b1_pr[0]) + 67'(b1_pr[1]) + 67'(b1_pr[2]);
      b2_cdneg <= b1_cdneg;
      b2_zero  <= b1_zero;
      b2_cc    <= b1_cc;
    end
  end

  // B3: round t
  logic [66:0] smag;
  logic [66:0] srnd;
  assign smag = b2_sum[66] ? 67'(-b2_sum) : 67'(b2_sum);
  assign srnd = smag + (67'(1) << (rsid_pkg::DIR_BITS - 1));

  logic                      b3_v;
  logic [rsid_pkg::TM_W-1:0] b3_tm;
  logic                      b3_tsign, b3_cdneg, b3_zero;
  logic [CCW-1:0]            b3_cc;

  always_ff @(posedge clk) begin
    if (rst) begin
      b3_v <= 1'b0;
    end else if (en) begin
      b3_v <= b2_v;
    end
    if (en) begin
      b3_tm    <= srnd[rsid_pkg::DIR_BITS +: rsid_pkg::TM_W];
      b3_tsign <= b2_sum[66];
      b3_cdneg <= b2_cdneg;
      b3_zero  <= b2_zero;
      b3_cc    <= b2_cc;
    end
  end

  // B4: t squared and scaled |c|^2
  logic                           b4_v;
  logic [2*rsid_pkg::TM_W-1:0]    b4_tt;
  logic [CW-1:0]                  b4_lhs;
  logic signed [rsid_pkg::T_W-1:0] b4_t;
  logic                           b4_cdneg, b4_zero;
  logic [CCW-1:0]                 b4_cc;

  always_ff @(posedge clk) begin
    if (rst) begin
      b4_v <= 1'b0;
    end else if (en) begin
      b4_v <= b3_v;
    end
    if (en) begin
      b4_tt    <= (2*rsid_pkg::TM_W)'(b3_tm) * (2*rsid_pkg::TM_W)'(b3_tm);
      b4_lhs   <= CW'(b3_cc) * CW'(TSQ);
      b4_t     <= b3_tsign ? -$signed({1'b0, b3_tm}) : $signed({1'b0, b3_tm});
      b4_cdneg <= b3_cdneg;
      b4_zero  <= b3_zero;
      b4_cc    <= b3_cc;
    end
  end

  // B5: h^2 and band tests
  logic [2*rsid_pkg::TM_W-1:0] ccx;
  assign ccx = (2*rsid_pkg::TM_W)'(b4_cc);

  logic                            b5_v;
  logic [CCW-1:0]                  b5_h2;
  logic                            b5_strict, b5_in_sph, b5_cdneg, b5_zero;
  logic signed [rsid_pkg::T_W-1:0] b5_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      b5_v <= 1'b0;
    end else if (en) begin
      b5_v <= b4_v;
    end
    if (en) begin
      b5_h2     <= (ccx > b4_tt) ? CCW'(ccx - b4_tt) : '0;
      b5_strict <= b4_lhs <= rs_lim;
      b5_in_sph <= b4_lhs < ri_lim;
      b5_cdneg  <= b4_cdneg;
      b5_zero   <= b4_zero;
      b5_t      <= b4_t;
    end
  end

  // B6: miss decision and chord radicand
  logic                b6_v;
  logic [RW-1:0]       b6_s2;
  rsid_pkg::rsid_sq2_t b6_p;

  always_ff @(posedge clk) begin
    if (rst) begin
      b6_v <= 1'b0;
    end else if (en) begin
      b6_v <= b5_v;
    end
    if (en) begin
      b6_s2       <= RW'(r2) - RW'(b5_h2);
      b6_p.t      <= b5_t;
      b6_p.in_sph <= b5_in_sph;
      b6_p.miss   <= b5_zero || (b5_h2 > CCW'(r2)) || (!b5_strict && b5_cdneg);
    end
  end

  // chord root
  logic                          sq2_v;
  logic [rsid_pkg::ROOT_W-1:0]   s_root;
  logic [rsid_pkg::ROOT_W:0]     s_rem;
  rsid_pkg::rsid_sq2_t           sq2_p;

  rsid_isqrt #(
    .PW ($bits(rsid_pkg::rsid_sq2_t))
  ) u_chord_root (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (b6_v),
    .radicand  (b6_s2),
    .in_pay    (b6_p),
    .out_valid (sq2_v),
    .root      (s_root),
    .rem       (s_rem),
    .out_pay   (sq2_p)
  );

  // E1: round root, then add it to or subtract it from t
  logic [32:0] s_r;
  assign s_r = {1'b0, s_root} + 33'(s_rem > {1'b0, s_root});

  logic               e1_v;
  logic signed [35:0] e1_val;
  logic               e1_miss, e1_in_sph;

  always_ff @(posedge clk) begin
    if (rst) begin
      e1_v <= 1'b0;
    end else if (en) begin
      e1_v <= sq2_v;
    end
    if (en) begin
      e1_val    <= sq2_p.in_sph ? 36'(sq2_p.t) + $signed({3'b0, s_r})
                                : 36'(sq2_p.t) - $signed({3'b0, s_r});
      e1_miss   <= sq2_p.miss;
      e1_in_sph <= sq2_p.in_sph;
    end
  end

  logic [35:0] vmag;
  logic [31:0] res_dist;
  logic        res_hit, res_inside;
  assign vmag       = e1_val[35] ? 36'(-e1_val) : 36'(e1_val);
  assign res_hit    = !e1_miss;
  assign res_inside = !e1_miss && e1_in_sph;
  assign res_dist   = e1_miss ? '0 : ((|vmag[35:32]) ? '1 : vmag[31:0]);

  // output register and skid
  logic        skid_hit, skid_inside;
  logic [31:0] skid_dist;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (out_ready) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end
      end else if (e1_v) begin
        if (!out_valid || out_ready) begin
          out_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_ready) begin
        hit        <= skid_hit;
        inside_res <= skid_inside;
        distance   <= skid_dist;
      end
    end else if (e1_v) begin
      if (!out_valid || out_ready) begin
        hit        <= res_hit;
        inside_res <= res_inside;
        distance   <= res_dist;
      end else begin
        skid_hit    <= res_hit;
        skid_inside <= res_inside;
        skid_dist   <= res_dist;
      end
    end
  end

`include "ray_sphere_intersect_distance_macros.svh"

  `RSID_ASSERT_NOW(a_skid_behind_out, skid_valid, out_valid)
  `RSID_ASSERT_NOW(a_miss_clean, out_valid && !hit, distance == '0 && !inside_res)
  `RSID_ASSERT_NEXT(a_skid_holds, skid_valid && !out_ready, skid_valid && out_valid)

endmodule
`default_nettype wire
